### design/nsl_pkg.sv
package nsl_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TASK = 3'd4;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    localparam logic [3:0] TYPE_UNTYPED = 4'd0;
    localparam logic [3:0] TYPE_OBJECT  = 4'd1;
    localparam logic [3:0] TYPE_FUNC    = 4'd2;

    localparam logic [31:0] WIN_END_RESET = 32'hC000_0000;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] size;
        logic [3:0]  sym_type;
        logic [31:0] name;
    } t_entry;

    typedef struct packed {
        logic             valid;
        logic             enable;
        logic [31:0]      rel;
        logic [CNT_W-1:0] j;
        logic             found;
        logic [IDX_W-1:0] best_idx;
        logic [31:0]      best_dist;
        logic [31:0]      best_name;
    } t_token;

endpackage

### design/nsl_cell.sv
module nsl_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  nsl_pkg::t_entry         i_wdata,
    input  logic [nsl_pkg::CNT_W-1:0] i_count,
    input  nsl_pkg::t_token         i_tok,
    output nsl_pkg::t_token         o_tok
);

    nsl_pkg::t_entry r_entry;
    nsl_pkg::t_token r_tok;
    nsl_pkg::t_token n_tok;

    logic [32:0] w_diff;
    logic [31:0] w_dist;
    logic        w_type_ok;
    logic        w_eligible;
    logic        w_better;
    logic        w_update;

    assign w_diff = {1'b0, i_tok.rel} - {1'b0, r_entry.value};
    assign w_dist = w_diff[31:0];
    assign w_type_ok = (r_entry.sym_type == nsl_pkg::TYPE_UNTYPED) ||
                       (r_entry.sym_type == nsl_pkg::TYPE_OBJECT) ||
                       (r_entry.sym_type == nsl_pkg::TYPE_FUNC);
    assign w_eligible = w_type_ok && (r_entry.value != 32'd0) && !w_diff[32] &&
                        ((r_entry.size == 32'd0) || (w_dist < r_entry.size));
    assign w_better = !i_tok.found || (w_dist < i_tok.best_dist);
    assign w_update = i_tok.valid && i_tok.enable && (i_tok.j < i_count) &&
                      w_eligible && w_better;

    always_comb begin
        n_tok   = i_tok;
        n_tok.j = i_tok.j + nsl_pkg::CNT_W'(1);
        if (w_update) begin
            n_tok.found     = 1'b1;
            n_tok.best_idx  = i_tok.j[nsl_pkg::IDX_W-1:0];
            n_tok.best_dist = w_dist;
            n_tok.best_name = r_entry.name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_entry <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### design/nearest_symbol_lookup.sv
// channel   direction  transaction                    payload
// s         in         tvalid & tready                tuser command, tdata entry and query
// m         out        tvalid & tready                tuser found, tdata match fields
// cfg       in         cfg_valid & cfg_ready          cfg_index register, cfg_data value
//
// a write item leaves the input ready for the next item; a resolve runs one token through MAX_SYMBOLS cells,
// one cell a cycle, after the launch register, and then through the hold and output registers
// the next item is taken only once the resolve's result has moved on from the hold register
// one finished result can wait in a hold register while the output is stalled
// synchronous active-low reset clears control state and config; table is undefined
module nearest_symbol_lookup (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // entry_index, symbol_value, symbol_size, symbol_type, symbol_name_offset,
    // query_address, zero pad
    input  logic [nsl_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // command
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // match_index, match_name_offset, offset_in_symbol
    output logic [nsl_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // found
    output logic                              o_m_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nsl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic [31:0]               r_load_base;
    logic [31:0]               r_win_start;
    logic [31:0]               r_win_end;
    logic [nsl_pkg::CNT_W-1:0] r_count;
    logic                      r_kernel;

    logic            r_busy;
    nsl_pkg::t_token r_launch;
    nsl_pkg::t_token n_launch;
    nsl_pkg::t_token r_hold;
    logic            r_hold_valid;
    nsl_pkg::t_token r_out;
    logic            r_out_valid;

    logic                            w_s_accept;
    logic                            w_wr;
    logic                            w_rd;
    logic [nsl_pkg::MAX_SYMBOLS-1:0] w_we;
    nsl_pkg::t_entry                 w_wdata;
    logic [31:0]                     w_addr;
    logic [31:0]                     w_cnt_in;
    logic                            w_out_free;
    nsl_pkg::t_token                 w_tok [nsl_pkg::MAX_SYMBOLS+1];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_busy && !r_hold_valid;
    assign w_s_accept  = i_s_tvalid && o_s_tready;
    assign w_wr        = w_s_accept && (i_s_tuser == nsl_pkg::CMD_WRITE);
    assign w_rd        = w_s_accept && (i_s_tuser == nsl_pkg::CMD_RESOLVE);

    assign w_wdata.value    = i_s_tdata[39:8];
    assign w_wdata.size     = i_s_tdata[71:40];
    assign w_wdata.sym_type = i_s_tdata[75:72];
    assign w_wdata.name     = i_s_tdata[107:76];
    assign w_addr           = i_s_tdata[139:108];
    assign w_cnt_in         = 32'(i_cfg_data[8:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base <= 32'd0;
            r_win_start <= 32'd0;
            r_win_end   <= nsl_pkg::WIN_END_RESET;
            r_count     <= '0;
            r_kernel    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                nsl_pkg::CFG_LOAD_BASE: begin
                    r_load_base <= i_cfg_data;
                end
                nsl_pkg::CFG_WIN_START: begin
                    r_win_start <= i_cfg_data;
                end
                nsl_pkg::CFG_WIN_END: begin
                    r_win_end <= i_cfg_data;
                end
                nsl_pkg::CFG_SYM_COUNT: begin
                    if (w_cnt_in > 32'(nsl_pkg::MAX_SYMBOLS)) begin
                        r_count <= nsl_pkg::CNT_W'(nsl_pkg::MAX_SYMBOLS);
                    end else begin
                        r_count <= nsl_pkg::CNT_W'(w_cnt_in);
                    end
                end
                nsl_pkg::CFG_KERNEL_TASK: begin
                    r_kernel <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // query check and rebase
    always_comb begin
        n_launch           = '0;
        n_launch.valid     = w_rd;
        n_launch.enable    = !r_kernel && (r_count != '0) &&
                             (w_addr >= r_win_start) && (w_addr < r_win_end);
        n_launch.rel       = w_addr - r_load_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= '0;
        end else begin
            r_launch <= n_launch;
        end
    end

    assign w_tok[0] = r_launch;

    genvar g;
    generate
        for (g = 0; g < nsl_pkg::MAX_SYMBOLS; g++) begin : g_cell
            assign w_we[g] = w_wr && (32'(i_s_tdata[7:0]) == 32'(g));
            nsl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_we    (w_we[g]),
                .i_wdata (w_wdata),
                .i_count (r_count),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_rd) begin
                r_busy <= 1'b1;
            end else if (w_tok[nsl_pkg::MAX_SYMBOLS].valid) begin
                r_busy <= 1'b0;
            end
            if (w_tok[nsl_pkg::MAX_SYMBOLS].valid) begin
                r_hold_valid <= 1'b1;
            end else if (w_out_free) begin
                r_hold_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_hold_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[nsl_pkg::MAX_SYMBOLS].valid) begin
            r_hold <= w_tok[nsl_pkg::MAX_SYMBOLS];
        end
        if (w_out_free && r_hold_valid) begin
            r_out <= r_hold;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.found;
    assign o_m_tdata  = {r_out.best_dist, r_out.best_name, 8'(r_out.best_idx)};

endmodule

### design/nsl_checker.sv
module nsl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [nsl_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input logic                              o_m_tuser
);

    logic w_s_accept;

    assign w_s_accept = i_s_tvalid && o_s_tready;

    // reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss result carries nonzero fields");

    a_resolve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept && (i_s_tuser == nsl_pkg::CMD_RESOLVE) |=> !o_s_tready)
        else $error("input taken while a scan runs");

    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept && (i_s_tuser == nsl_pkg::CMD_WRITE) |=> o_s_tready)
        else $error("table write blocked the input");

endmodule

bind nearest_symbol_lookup nsl_checker u_nsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

### verif/nearest_symbol_lookup_tb.sv
module nearest_symbol_lookup_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nsl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [31:0] REGION = 32'h0040_0000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 40;

    typedef struct {
        logic        cmd;
        logic [7:0]  entry;
        logic [31:0] value;
        logic [31:0] size;
        logic [3:0]  kind;
        logic [31:0] name;
        logic [31:0] addr;
    } sym_op_t;

    typedef struct {
        logic        found;
        logic [7:0]  slot;
        logic [31:0] name;
        logic [31:0] offset;
    } sym_hit_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [31:0]             cfg_data;

    // predictor copy of the registers and the symbol table
    logic [31:0] cfg_load_base;
    logic [31:0] cfg_win_lo;
    logic [31:0] cfg_win_hi;
    logic [8:0]  cfg_count;
    logic        cfg_kernel;
    logic [31:0] tbl_value [MAX_SYMBOLS];
    logic [31:0] tbl_size  [MAX_SYMBOLS];
    logic [3:0]  tbl_kind  [MAX_SYMBOLS];
    logic [31:0] tbl_name  [MAX_SYMBOLS];

    // table contents as planned by the stimulus, ahead of acceptance
    logic [31:0] plan_value [MAX_SYMBOLS];
    bit          plan_set   [MAX_SYMBOLS];

    sym_op_t  op_q[$];
    sym_hit_t hit_q[$];
    sym_op_t  cur_op;
    int       items_left = 0;
    int       err_cnt = 0;
    int       s_gap = 0;
    bit       s_quiet = 1'b0;
    int       m_hold = 0;
    bit       m_quiet = 1'b0;

    nearest_symbol_lookup i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic bit eligible_kind(input logic [3:0] kind);
        return kind == TYPE_UNTYPED || kind == TYPE_OBJECT || kind == TYPE_FUNC;
    endfunction

    function automatic int live_count(input logic [8:0] count);
        return (count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(count);
    endfunction

    function automatic sym_hit_t nearest_symbol(input logic [31:0] addr);
        sym_hit_t    r;
        logic [31:0] rel;
        logic [31:0] delta;
        int          n;
        r = '{found: 1'b0, slot: 8'd0, name: 32'd0, offset: 32'd0};
        n = live_count(cfg_count);
        if (cfg_kernel == 1'b0 && n != 0 && addr >= cfg_win_lo && addr < cfg_win_hi) begin
            rel = addr - cfg_load_base;
            for (int j = 0; j < n; j++) begin
                if (tbl_value[j] != 32'd0 && tbl_value[j] <= rel && eligible_kind(tbl_kind[j])) begin
                    delta = rel - tbl_value[j];
                    if (tbl_size[j] == 32'd0 || delta < tbl_size[j]) begin
                        if (!r.found || delta < r.offset) begin
                            r.found  = 1'b1;
                            r.slot   = j[7:0];
                            r.name   = tbl_name[j];
                            r.offset = delta;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_draw(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // input side
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_op.cmd == CMD_WRITE) begin
                    tbl_value[cur_op.entry] = cur_op.value;
                    tbl_size[cur_op.entry]  = cur_op.size;
                    tbl_kind[cur_op.entry]  = cur_op.kind;
                    tbl_name[cur_op.entry]  = cur_op.name;
                end else begin
                    hit_q.push_back(nearest_symbol(cur_op.addr));
                end
                items_left--;
                if ($urandom_range(0, 39) == 0)
                    s_quiet = !s_quiet;
                s_gap = gap_draw(s_quiet);
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (op_q.size() != 0) begin
                    cur_op   <= op_q[0];
                    s_tdata  <= {4'b0, op_q[0].addr, op_q[0].name, op_q[0].kind,
                                 op_q[0].size, op_q[0].value, op_q[0].entry};
                    s_tuser  <= op_q[0].cmd;
                    s_tvalid <= 1'b1;
                    void'(op_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk) begin
        sym_hit_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (hit_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result: expected none, actual found=%0b tdata=%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = hit_q.pop_front();
                    if (m_tuser !== want.found || m_tdata[7:0] !== want.slot ||
                        m_tdata[39:8] !== want.name || m_tdata[71:40] !== want.offset) begin
                        err_cnt++;
                        if (m_tuser !== want.found)
                            $display("%0t: found expected %0b actual %0b",
                                     $time, want.found, m_tuser);
                        if (m_tdata[7:0] !== want.slot)
                            $display("%0t: match_index expected %0d actual %0d",
                                     $time, want.slot, m_tdata[7:0]);
                        if (m_tdata[39:8] !== want.name)
                            $display("%0t: match_name_offset expected %h actual %h",
                                     $time, want.name, m_tdata[39:8]);
                        if (m_tdata[71:40] !== want.offset)
                            $display("%0t: offset_in_symbol expected %h actual %h",
                                     $time, want.offset, m_tdata[71:40]);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    m_quiet = !m_quiet;
                m_hold = gap_draw(m_quiet);
            end
            if (m_hold > 0) begin
                m_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_LOAD_BASE:   cfg_load_base = data;
            CFG_WIN_START:   cfg_win_lo    = data;
            CFG_WIN_END:     cfg_win_hi    = data;
            CFG_SYM_COUNT:   cfg_count     = data[8:0];
            CFG_KERNEL_TASK: cfg_kernel    = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_write(input logic [7:0] entry, input logic [31:0] value,
                               input logic [31:0] size, input logic [3:0] kind,
                               input logic [31:0] name);
        sym_op_t op;
        op.cmd   = CMD_WRITE;
        op.entry = entry;
        op.value = value;
        op.size  = size;
        op.kind  = kind;
        op.name  = name;
        op.addr  = $urandom;
        plan_value[entry] = value;
        plan_set[entry]   = 1'b1;
        op_q.push_back(op);
        items_left++;
    endtask

    task automatic queue_resolve(input logic [31:0] addr);
        sym_op_t op;
        op.cmd   = CMD_RESOLVE;
        op.entry = 8'($urandom);
        op.value = $urandom;
        op.size  = $urandom;
        op.kind  = 4'($urandom);
        op.name  = $urandom;
        op.addr  = addr;
        op_q.push_back(op);
        items_left++;
    endtask

    task automatic queue_random_write(input logic [7:0] entry);
        logic [31:0] value;
        logic [31:0] size;
        logic [3:0]  kind;
        int          p;
        p = $urandom_range(0, 99);
        if (p < 5)
            value = 32'd0;
        else if (p < 8)
            value = 32'hFFFF_FFFF;
        else if (p < 20)
            value = $urandom;
        else if (p < 28)
            value = plan_value[$urandom_range(0, MAX_SYMBOLS - 1)];
        else
            value = REGION + $urandom_range(0, 'hFFFF);
        p = $urandom_range(0, 99);
        if (p < 40)
            size = 32'd0;
        else if (p < 80)
            size = $urandom_range(1, 'h800);
        else if (p < 90)
            size = $urandom;
        else if (p < 95)
            size = 32'd1;
        else
            size = 32'hFFFF_FFFF;
        kind = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 2))
                                            : 4'($urandom_range(0, 15));
        queue_write(entry, value, size, kind, $urandom);
    endtask

    task automatic queue_random_query(input int n_eff);
        logic [31:0] addr;
        int          p;
        p = $urandom_range(0, 99);
        if (p < 60 && n_eff != 0)
            addr = plan_value[$urandom_range(0, n_eff - 1)] + $urandom_range(0, 'h400)
                   + cfg_load_base;
        else if (p < 75)
            addr = REGION + $urandom_range(0, 'h10000) + cfg_load_base;
        else if (p < 90)
            addr = $urandom;
        else begin
            case ($urandom_range(0, 3))
                0: addr = cfg_win_lo;
                1: addr = cfg_win_lo - 32'd1;
                2: addr = cfg_win_hi;
                default: addr = cfg_win_hi - 32'd1;
            endcase
        end
        queue_resolve(addr);
    endtask

    task automatic settle();
        while (items_left != 0 || hit_q.size() != 0)
            @(posedge clk);
        repeat (MAX_SYMBOLS + 8) @(posedge clk);
    endtask

    initial begin
        logic [31:0] lb;
        logic [31:0] ws;
        logic [31:0] we;
        logic [8:0]  cnt;
        logic        kt;
        int          n_eff;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        cfg_load_base = 32'd0;
        cfg_win_lo    = 32'd0;
        cfg_win_hi    = WIN_END_RESET;
        cfg_count     = 9'd0;
        cfg_kernel    = 1'b1;
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            tbl_value[j]  = 32'd0;
            tbl_size[j]   = 32'd0;
            tbl_kind[j]   = 4'd0;
            tbl_name[j]   = 32'd0;
            plan_value[j] = 32'd0;
            plan_set[j]   = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: kernel task rejects everything
        queue_resolve(32'h0000_1000);
        queue_write(8'd0, 32'h0000_1000, 32'h100, TYPE_FUNC, 32'hFFFF_FFFF);
        queue_write(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'd0);
        settle();

        // user task but no table loaded
        reg_write(CFG_KERNEL_TASK, 32'd0);
        queue_resolve(32'h0000_1000);
        settle();

        // small table with ties, size limits, ineligible type and zero value
        reg_write(CFG_SYM_COUNT, 32'd6);
        reg_write(CFG_WIN_START, 32'h0000_0100);
        queue_write(8'd1, 32'h0000_1000, 32'd0, TYPE_UNTYPED, 32'h11);
        queue_write(8'd2, 32'h0000_2000, 32'h10, TYPE_OBJECT, 32'h22);
        queue_write(8'd3, 32'h0000_1800, 32'd0, 4'd3, 32'h33);
        queue_write(8'd4, 32'd0, 32'd0, TYPE_FUNC, 32'h44);
        queue_write(8'd5, 32'h0000_3000, 32'd1, TYPE_FUNC, 32'h55);
        queue_resolve(32'h0000_1000);
        queue_resolve(32'h0000_1080);
        queue_resolve(32'h0000_1100);
        queue_resolve(32'h0000_1900);
        queue_resolve(32'h0000_200F);
        queue_resolve(32'h0000_2010);
        queue_resolve(32'h0000_3000);
        queue_resolve(32'h0000_3001);
        queue_resolve(32'h0000_0FFF);
        queue_resolve(32'h0000_00FF);
        queue_resolve(32'hC000_0000);
        queue_resolve(32'hBFFF_FFFF);
        settle();

        // load base wraps the relative address
        reg_write(CFG_LOAD_BASE, 32'hFFFF_F000);
        reg_write(CFG_WIN_START, 32'd0);
        reg_write(CFG_WIN_END, 32'hFFFF_FFFF);
        reg_write(CFG_SPARE, $urandom);
        queue_resolve(32'h0000_0000);
        queue_resolve(32'hFFFF_F000);
        queue_resolve(32'hFFFF_FFFF);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: lb = 32'd0;
                4:          lb = 32'hFFFF_FFFF;
                5, 6:       lb = 32'hFFF0_0000;
                default:    lb = $urandom;
            endcase
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4: begin
                    ws = 32'd0;
                    we = 32'hFFFF_FFFF;
                end
                5: begin
                    ws = 32'd0;
                    we = WIN_END_RESET;
                end
                6, 7: begin
                    ws = lb + REGION + $urandom_range(0, 'h8000);
                    we = ws + $urandom_range(1, 'h10000);
                end
                8: begin
                    ws = 32'hFFFF_FFFF;
                    we = 32'hFFFF_FFFF;
                end
                9: begin
                    ws = 32'd0;
                    we = 32'd0;
                end
                default: begin
                    ws = $urandom;
                    we = $urandom;
                end
            endcase
            case (p)
                0:       cnt = 9'd256;
                1:       cnt = 9'd511;
                2:       cnt = 9'd1;
                4:       cnt = 9'd0;
                default: cnt = 9'($urandom_range(1, 300));
            endcase
            kt = (p == 3) ? 1'b1 : ($urandom_range(0, 9) == 0);
            reg_write(CFG_LOAD_BASE, lb);
            reg_write(CFG_WIN_START, ws);
            reg_write(CFG_WIN_END, we);
            reg_write(CFG_SYM_COUNT, {23'($urandom_range(0, 'h7F_FFFF)), cnt});
            reg_write(CFG_KERNEL_TASK, {31'($urandom_range(0, 'h7FFF_FFFF)), kt});
            if ($urandom_range(0, 3) == 0)
                reg_write(CFG_SPARE, $urandom);
            n_eff = live_count(cnt);
            for (int j = 0; j < n_eff; j++)
                if (!plan_set[j])
                    queue_random_write(j[7:0]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 30)
                    queue_random_write(8'($urandom_range(0, MAX_SYMBOLS - 1)));
                else
                    queue_random_query(n_eff);
            end
            settle();
        end

        if (err_cnt == 0 && hit_q.size() == 0)
            $display("nearest_symbol_lookup_tb: done, clean");
        else
            $display("nearest_symbol_lookup_tb: done, errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("%0t: timeout", $time);
        $display("nearest_symbol_lookup_tb: done, errors");
        $finish;
    end

endmodule
